[design/bdrd_pkg.sv]
// Shared types and constants of the byte difference run delta encoder.
// No dependencies; every other design file refers to it by scoped names.
package bdrd_pkg;

    // Result record kinds, carried on m_tuser
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Run counter width and saturation value
    localparam int          RUN_TOTAL_W   = 15;
    localparam logic [14:0] RUN_TOTAL_MAX = 15'h7FFF;

    // Configuration port
    localparam int          APB_ADDR_W       = 3;
    localparam logic [0:0]  REG_SNAPSHOT_KEY = 1'b0;

    // Command queue between front and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

[design/bdrd_front.sv]
// Front end: accepts byte pairs, tracks run state and issues one command per
// item that has results. Uses bdrd_pkg for queue status and run constants.
module bdrd_front #(
    parameter int MAX_FRAME_BYTES = 262144,
    parameter int MERGE_GAP       = 8,
    localparam int POS_W     = ($clog2(MAX_FRAME_BYTES) > 0) ? $clog2(MAX_FRAME_BYTES) : 1,
    localparam int GC_W      = ($clog2(MERGE_GAP) > 0) ? $clog2(MERGE_GAP) : 1,
    localparam int GAP_DEPTH = (MERGE_GAP > 1) ? MERGE_GAP - 1 : 1,
    localparam int CMD_W     = GC_W + GAP_DEPTH * 8 + 1 + 8 + 1 + POS_W + POS_W + 1 + 1
                               + bdrd_pkg::RUN_TOTAL_W
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,   // current_byte [7:0], reference_byte [15:8]
    input  logic                    s_tlast,   // frame_end
    input  bdrd_pkg::queue_status_t q_status,
    output logic                    push,
    output logic [CMD_W-1:0]        cmd
);

    localparam int GI_W = ($clog2(GAP_DEPTH) > 0) ? $clog2(GAP_DEPTH) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);
    localparam logic [GC_W-1:0]  GAP_FULL = GC_W'(MERGE_GAP - 1);

    typedef struct packed {
        logic [GC_W-1:0]                gap_cnt;
        logic [GAP_DEPTH-1:0][7:0]      gap_bytes;
        logic                           emit_cur;
        logic [7:0]                     cur_byte;
        logic                           close;
        logic [POS_W-1:0]               start;
        logic [POS_W:0]                 length;
        logic                           done;
        logic [bdrd_pkg::RUN_TOTAL_W-1:0] total;
    } cmd_t;

    logic [POS_W-1:0]                 position_reg, position_next;
    logic                             run_open_reg, run_open_next;
    logic [POS_W-1:0]                 run_start_reg, run_start_next;
    logic [POS_W-1:0]                 last_diff_reg, last_diff_next;
    logic [GC_W-1:0]                  gap_count_reg, gap_count_next;
    logic [bdrd_pkg::RUN_TOTAL_W-1:0] runs_reg, runs_next;
    logic [GAP_DEPTH-1:0][7:0]        gap_mem_reg;

    logic       accept, last, diff, gap_full, open_mid, close, store;
    logic [7:0] cur_byte;
    logic [POS_W-1:0] start_now, lastd_now;
    logic [bdrd_pkg::RUN_TOTAL_W-1:0] runs_after;
    cmd_t       cmd_s;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign cur_byte = s_tdata[7:0];

    // Classify the item against the open run
    always_comb begin
        last     = s_tlast || (position_reg == POS_LAST);
        diff     = s_tdata[7:0] != s_tdata[15:8];
        gap_full = gap_count_reg >= GAP_FULL;
        open_mid = run_open_reg ? (diff || !gap_full) : diff;
        close    = (run_open_reg && !diff && gap_full) || (last && open_mid);
        store    = run_open_reg && !diff && !gap_full;
        start_now = run_open_reg ? run_start_reg : position_reg;
        lastd_now = diff ? position_reg : last_diff_reg;
        if (close && (runs_reg != bdrd_pkg::RUN_TOTAL_MAX)) begin
            runs_after = runs_reg + 1'b1;
        end else begin
            runs_after = runs_reg;
        end
    end

    // Command for the back end
    always_comb begin
        cmd_s.gap_cnt   = (run_open_reg && diff) ? gap_count_reg : '0;
        cmd_s.gap_bytes = gap_mem_reg;
        cmd_s.emit_cur  = diff;
        cmd_s.cur_byte  = cur_byte;
        cmd_s.close     = close;
        cmd_s.start     = start_now;
        cmd_s.length    = {1'b0, lastd_now} - {1'b0, start_now} + 1'b1;
        cmd_s.done      = last;
        cmd_s.total     = runs_after;
    end

    assign cmd  = cmd_s;
    assign push = accept && (diff || close || last);

    // Next state
    always_comb begin
        position_next  = last ? '0 : position_reg + 1'b1;
        runs_next      = last ? '0 : runs_after;
        run_open_next  = !last && open_mid;
        run_start_next = (!run_open_reg && diff) ? position_reg : run_start_reg;
        last_diff_next = diff ? position_reg : last_diff_reg;
        gap_count_next = (store && !last) ? gap_count_reg + 1'b1 : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            last_diff_reg <= '0;
            gap_count_reg <= '0;
            runs_reg      <= '0;
        end else if (accept) begin
            position_reg  <= position_next;
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            last_diff_reg <= last_diff_next;
            gap_count_reg <= gap_count_next;
            runs_reg      <= runs_next;
        end
    end

    // Held equal bytes of the open run
    always_ff @(posedge aclk) begin
        if (accept && store) begin
            gap_mem_reg[gap_count_reg[GI_W-1:0]] <= cur_byte;
        end
    end

endmodule

[design/bdrd_queue.sv]
// Short command queue between front and back end, register based.
// Depth and pointer widths come from bdrd_pkg; payload width is a parameter.
module bdrd_queue #(
    parameter int WIDTH = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        head_data,
    output bdrd_pkg::queue_status_t status
);

    logic [bdrd_pkg::QUEUE_DEPTH-1:0][WIDTH-1:0] entry_reg;
    logic [bdrd_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [bdrd_pkg::QCNT_W-1:0] count_reg, count_next;

    assign status.full  = count_reg == bdrd_pkg::QCNT_W'(bdrd_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head_data    = entry_reg[rd_ptr_reg];

    // Occupancy
    always_comb begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/bdrd_back.sv]
// Back end: walks the head command and emits its records one per cycle into the
// output register unless the output stalls. Uses bdrd_pkg for record kinds, queue status.
module bdrd_back #(
    parameter int MAX_FRAME_BYTES = 262144,
    parameter int MERGE_GAP       = 8,
    localparam int POS_W     = ($clog2(MAX_FRAME_BYTES) > 0) ? $clog2(MAX_FRAME_BYTES) : 1,
    localparam int GC_W      = ($clog2(MERGE_GAP) > 0) ? $clog2(MERGE_GAP) : 1,
    localparam int GAP_DEPTH = (MERGE_GAP > 1) ? MERGE_GAP - 1 : 1,
    localparam int CMD_W     = GC_W + GAP_DEPTH * 8 + 1 + 8 + 1 + POS_W + POS_W + 1 + 1
                               + bdrd_pkg::RUN_TOTAL_W,
    localparam int RAW_W     = 8 + POS_W + POS_W + 1 + bdrd_pkg::RUN_TOTAL_W,
    localparam int TDATA_W   = ((RAW_W + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [CMD_W-1:0]        head_data,
    input  bdrd_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_W-1:0]      m_tdata,  // data_byte, run_start, run_length, run_total
    output logic [1:0]              m_tuser,  // record_kind
    output logic                    m_tlast   // burst_last
);

    localparam int GI_W = ($clog2(GAP_DEPTH) > 0) ? $clog2(GAP_DEPTH) : 1;
    localparam int P_W  = $clog2(MERGE_GAP + 3);
    localparam int OFS_START  = 8;
    localparam int OFS_LENGTH = OFS_START + POS_W;
    localparam int OFS_TOTAL  = OFS_LENGTH + POS_W + 1;

    typedef struct packed {
        logic [GC_W-1:0]                gap_cnt;
        logic [GAP_DEPTH-1:0][7:0]      gap_bytes;
        logic                           emit_cur;
        logic [7:0]                     cur_byte;
        logic                           close;
        logic [POS_W-1:0]               start;
        logic [POS_W:0]                 length;
        logic                           done;
        logic [bdrd_pkg::RUN_TOTAL_W-1:0] total;
    } cmd_t;

    cmd_t               c;
    logic [P_W-1:0]     step_reg, step_next;
    logic               m_tvalid_reg, m_tlast_reg;
    logic [1:0]         m_tuser_reg;
    logic [TDATA_W-1:0] m_tdata_reg;

    logic [P_W-1:0]     n_gap, n_total, rest;
    logic               load, burst_end;
    logic [1:0]         kind_next;
    logic [TDATA_W-1:0] tdata_next;

    assign c    = head_data;
    assign load = !q_status.empty && (!m_tvalid_reg || m_tready);

    // Pick the record at the current step of the head command
    always_comb begin
        n_gap     = P_W'(c.gap_cnt);
        n_total   = n_gap + P_W'(c.emit_cur) + P_W'(c.close) + P_W'(c.done);
        rest      = step_reg - n_gap;
        burst_end = step_reg == (n_total - 1'b1);
        tdata_next = '0;
        priority if (step_reg < n_gap) begin
            kind_next        = bdrd_pkg::KIND_DATA;
            tdata_next[7:0]  = c.gap_bytes[step_reg[GI_W-1:0]];
        end else if (c.emit_cur && (rest == '0)) begin
            kind_next        = bdrd_pkg::KIND_DATA;
            tdata_next[7:0]  = c.cur_byte;
        end else if (c.close && (rest == P_W'(c.emit_cur))) begin
            kind_next = bdrd_pkg::KIND_CLOSE;
            tdata_next[OFS_START +: POS_W]    = c.start;
            tdata_next[OFS_LENGTH +: POS_W+1] = c.length;
        end else begin
            kind_next = bdrd_pkg::KIND_DONE;
            tdata_next[OFS_TOTAL +: bdrd_pkg::RUN_TOTAL_W] = c.total;
        end
        step_next = burst_end ? '0 : step_reg + 1'b1;
    end

    assign pop = load && burst_end;

    // Step counter and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                step_reg     <= step_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= tdata_next;
            m_tuser_reg <= kind_next;
            m_tlast_reg <= burst_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[design/byte_diff_run_delta_encoder_core.sv]
// Byte difference run delta encoder. The first record of an item passes through the
// command queue and then the output register, which holds each record in turn.
// Takes one byte pair per cycle while items yield at most one record and m_tready holds;
// a multi-record item holds the back end, and a four-entry command queue absorbs it.
// aresetn is synchronous, active low: clears run state, queue and output valid.
// Depends on bdrd_pkg, bdrd_front, bdrd_queue and bdrd_back.
module byte_diff_run_delta_encoder_core #(
    parameter int MAX_FRAME_BYTES = 262144,
    parameter int MERGE_GAP       = 8,
    localparam int POS_W     = ($clog2(MAX_FRAME_BYTES) > 0) ? $clog2(MAX_FRAME_BYTES) : 1,
    localparam int RAW_W     = 8 + POS_W + POS_W + 1 + bdrd_pkg::RUN_TOTAL_W,
    localparam int TDATA_W   = ((RAW_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // current_byte [7:0], reference_byte [15:8]
    input  logic                          s_tlast,  // frame_end
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata,  // data_byte, run_start, run_length, run_total
    output logic [1:0]                    m_tuser,  // record_kind
    output logic                          m_tlast,  // burst_last
    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdrd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int GC_W      = ($clog2(MERGE_GAP) > 0) ? $clog2(MERGE_GAP) : 1;
    localparam int GAP_DEPTH = (MERGE_GAP > 1) ? MERGE_GAP - 1 : 1;
    localparam int CMD_W     = GC_W + GAP_DEPTH * 8 + 1 + 8 + 1 + POS_W + POS_W + 1 + 1
                               + bdrd_pkg::RUN_TOTAL_W;

    logic [31:0]             snapshot_key_reg;
    logic                    cfg_write, key_sel;
    logic                    push, pop;
    logic [CMD_W-1:0]        push_cmd, head_cmd;
    bdrd_pkg::queue_status_t q_status;

    // Configuration register
    assign pready    = 1'b1;
    assign key_sel   = paddr[2:2] == bdrd_pkg::REG_SNAPSHOT_KEY;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = key_sel ? snapshot_key_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snapshot_key_reg <= '0;
        end else if (cfg_write && key_sel) begin
            snapshot_key_reg <= pwdata;
        end
    end

    bdrd_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .MERGE_GAP      (MERGE_GAP)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_status(q_status),
        .push    (push),
        .cmd     (push_cmd)
    );

    bdrd_queue #(
        .WIDTH(CMD_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_cmd),
        .pop      (pop),
        .head_data(head_cmd),
        .status   (q_status)
    );

    bdrd_back #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .MERGE_GAP      (MERGE_GAP)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_data(head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef ASSERT_OFF
    // Frame done is always the final record of its item
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == bdrd_pkg::KIND_DONE)) |-> m_tlast)
        else $error("frame done record without burst_last");

    // Data records carry only the data byte
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == bdrd_pkg::KIND_DATA)) |-> (m_tdata[TDATA_W-1:8] == '0))
        else $error("data record with nonzero run fields");

    // Queue occupancy flags stay consistent
    a_queue_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("command queue both full and empty");

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
